### hdl/crk_pkg.sv
// ----------------------------------------------------------------------------
// crk_pkg
// shared types, operation codes, operand codes and the microprogram for the
// rk4 chua step engine
// ----------------------------------------------------------------------------
package crk_pkg;

   localparam int unsigned QW      = 32;   // q8.24 word
   localparam int unsigned TW      = 36;   // scratch word, holds exact weighted sums
   localparam int unsigned PW      = 72;   // product width
   localparam int unsigned FRAC    = 24;
   localparam int unsigned TIMEW   = 40;
   localparam int unsigned STEPW   = 31;
   localparam int unsigned CNTW    = 16;
   localparam int unsigned NREG    = 8;
   localparam int unsigned RAMD    = 32;

   localparam logic [TIMEW-1:0] TIME_MAX  = {TIMEW{1'b1}};
   localparam logic [CNTW-1:0]  COUNT_MAX = {CNTW{1'b1}};

   // shared unit operations
   localparam logic [3:0] OP_MUL   = 4'd0;   // sat32(floor(a*b / 2^24))
   localparam logic [3:0] OP_DIV3  = 4'd1;   // floor(a*b / 2^33), b is the reciprocal of 3
   localparam logic [3:0] OP_MULST = 4'd2;   // floor(a*b / 2^24) clamped to step range
   localparam logic [3:0] OP_ADD   = 4'd3;   // exact a+b
   localparam logic [3:0] OP_ADDS  = 4'd4;   // sat32(a+b)
   localparam logic [3:0] OP_SUBS  = 4'd5;   // sat32(a-b)
   localparam logic [3:0] OP_NSUBS = 4'd6;   // sat32(-a-b)
   localparam logic [3:0] OP_ABSD  = 4'd7;   // sat32(|a-b| - |a+b|)
   localparam logic [3:0] OP_SUBH  = 4'd8;   // floor(sat32(a-b) / 2)
   localparam logic [3:0] OP_SHR1  = 4'd9;   // floor(a / 2)

   // operand codes: 0..31 scratch ram, then register halves and state
   localparam logic [5:0] S_INV_RC1 = 6'd32;
   localparam logic [5:0] S_INV_C1  = 6'd33;
   localparam logic [5:0] S_INV_RC2 = 6'd34;
   localparam logic [5:0] S_INV_C2  = 6'd35;
   localparam logic [5:0] S_INV_L   = 6'd36;
   localparam logic [5:0] S_RO      = 6'd37;
   localparam logic [5:0] S_M0      = 6'd38;
   localparam logic [5:0] S_M1      = 6'd39;
   localparam logic [5:0] S_M2      = 6'd40;
   localparam logic [5:0] S_BIAS    = 6'd41;
   localparam logic [5:0] S_BP      = 6'd42;
   localparam logic [5:0] S_B0      = 6'd43;
   localparam logic [5:0] S_H0      = 6'd44;
   localparam logic [5:0] S_GROW    = 6'd45;
   localparam logic [5:0] S_ILIM    = 6'd46;
   localparam logic [5:0] S_ULIM    = 6'd47;
   localparam logic [5:0] S_CUR     = 6'd48;
   localparam logic [5:0] S_V1      = 6'd49;
   localparam logic [5:0] S_V2      = 6'd50;
   localparam logic [5:0] S_STEP    = 6'd51;
   localparam logic [5:0] S_RECIP3  = 6'd52;
   localparam logic [5:0] S_ZERO    = 6'd53;

   localparam logic [TW-1:0] RECIP3 = 36'h0AAAAAAAB;

   // scratch slots
   localparam logic [5:0] T_H2  = 6'd0;
   localparam logic [5:0] T_H6  = 6'd1;
   localparam logic [5:0] T_H10 = 6'd2;
   localparam logic [5:0] T_H21 = 6'd3;
   localparam logic [5:0] T_Y0  = 6'd4;
   localparam logic [5:0] T_P   = 6'd7;
   localparam logic [5:0] T_Q   = 6'd8;
   localparam logic [5:0] T_R   = 6'd9;
   localparam logic [5:0] T_S0  = 6'd12;
   localparam logic [5:0] T_K0  = 6'd15;
   localparam logic [5:0] T_D0  = 6'd18;
   localparam logic [5:0] T_N0  = 6'd21;
   localparam logic [5:0] T_G   = 6'd24;

   // microprogram phases
   localparam logic [1:0] PH_PRE   = 2'd0;
   localparam logic [1:0] PH_SLOPE = 2'd1;
   localparam logic [1:0] PH_POST  = 2'd2;
   localparam logic [1:0] PH_FINAL = 2'd3;

   typedef struct packed {
      logic [3:0] op;
      logic [5:0] src_a;
      logic [5:0] src_b;
      logic [4:0] dst;
   } instr_type;

   typedef struct packed {
      logic            we;
      logic [4:0]      waddr;
      logic [4:0]      raddr_a;
      logic [4:0]      raddr_b;
   } ram_ctl_type;

   function automatic logic signed [TW-1:0] crk_sat32(input logic signed [PW-1:0] v);
      logic signed [TW-1:0] r;
      if (v > 72'sd2147483647) r = 36'sd2147483647;
      else if (v < -72'sd2147483648) r = -36'sd2147483648;
      else r = v[TW-1:0];
      return r;
   endfunction

   function automatic logic [4:0] crk_last(input logic [1:0] phase, input logic [1:0] stage);
      logic [4:0] r;
      case (phase)
         PH_PRE:   r = 5'd3;
         PH_SLOPE: r = 5'd18;
         PH_POST: begin
            case (stage)
               2'd0:    r = 5'd8;
               2'd3:    r = 5'd2;
               default: r = 5'd11;
            endcase
         end
         default:  r = 5'd6;
      endcase
      return r;
   endfunction

   function automatic instr_type mk(input logic [3:0] op, input logic [5:0] a,
                                    input logic [5:0] b, input logic [5:0] d);
      instr_type r;
      r.op    = op;
      r.src_a = a;
      r.src_b = b;
      r.dst   = d[4:0];
      return r;
   endfunction

   function automatic instr_type crk_instr(input logic [1:0] phase, input logic [1:0] stage,
                                           input logic [4:0] idx);
      instr_type  ins;
      logic [5:0] si;
      logic [5:0] su1;
      logic [5:0] su2;
      logic [5:0] hsrc;
      logic [5:0] n;
      logic [4:0] j;
      logic       short;
      short = (stage == 2'd0) || (stage == 2'd3);
      si    = (stage == 2'd0) ? S_CUR : T_Y0;
      su1   = (stage == 2'd0) ? S_V1  : T_Y0 + 6'd1;
      su2   = (stage == 2'd0) ? S_V2  : T_Y0 + 6'd2;
      hsrc  = (stage == 2'd2) ? S_STEP : T_H2;
      j     = 5'd0;
      n     = 6'd0;
      ins   = mk(OP_ADD, S_ZERO, S_ZERO, T_R);
      case (phase)
         PH_PRE: begin
            case (idx)
               5'd0:    ins = mk(OP_SHR1, S_STEP, S_ZERO, T_H2);
               5'd1:    ins = mk(OP_DIV3, T_H2, S_RECIP3, T_H6);
               5'd2:    ins = mk(OP_SUBH, S_M1, S_M0, T_H10);
               default: ins = mk(OP_SUBH, S_M2, S_M1, T_H21);
            endcase
         end
         PH_SLOPE: begin
            case (idx)
               5'd0:    ins = mk(OP_MUL,   S_RO, si, T_P);
               5'd1:    ins = mk(OP_NSUBS, su2, T_P, T_P);
               5'd2:    ins = mk(OP_MUL,   T_P, S_INV_L, T_K0);
               5'd3:    ins = mk(OP_SUBS,  su2, su1, T_P);
               5'd4:    ins = mk(OP_MUL,   T_P, S_INV_RC1, T_Q);
               5'd5:    ins = mk(OP_MUL,   S_M2, su1, T_P);
               5'd6:    ins = mk(OP_ABSD,  su1, S_BP, T_R);
               5'd7:    ins = mk(OP_MUL,   T_H10, T_R, T_R);
               5'd8:    ins = mk(OP_ADD,   T_P, T_R, T_P);
               5'd9:    ins = mk(OP_ABSD,  su1, S_B0, T_R);
               5'd10:   ins = mk(OP_MUL,   T_H21, T_R, T_R);
               5'd11:   ins = mk(OP_ADDS,  T_P, T_R, T_P);
               5'd12:   ins = mk(OP_ADDS,  T_P, S_BIAS, T_P);
               5'd13:   ins = mk(OP_MUL,   T_P, S_INV_C1, T_P);
               5'd14:   ins = mk(OP_SUBS,  T_Q, T_P, T_K0 + 6'd1);
               5'd15:   ins = mk(OP_SUBS,  su1, su2, T_P);
               5'd16:   ins = mk(OP_MUL,   T_P, S_INV_RC2, T_P);
               5'd17:   ins = mk(OP_MUL,   si, S_INV_C2, T_Q);
               default: ins = mk(OP_ADDS,  T_P, T_Q, T_K0 + 6'd2);
            endcase
         end
         PH_POST: begin
            if (short && idx < 5'd3) begin
               n = {4'd0, idx[1:0]};
               if (stage == 2'd0) ins = mk(OP_ADD, T_K0 + n, S_ZERO, T_S0 + n);
               else ins = mk(OP_ADD, T_S0 + n, T_K0 + n, T_S0 + n);
            end else if (!short && idx < 5'd6) begin
               n = {4'd0, idx[2:1]};
               ins = mk(OP_ADD, T_S0 + n, T_K0 + n, T_S0 + n);
            end else begin
               j = short ? idx - 5'd3 : idx - 5'd6;
               n = {4'd0, j[2:1]};
               if (!j[0]) ins = mk(OP_MUL, hsrc, T_K0 + n, T_P);
               else ins = mk(OP_ADDS, S_CUR + n, T_P, T_Y0 + n);
            end
         end
         default: begin
            n = {4'd0, idx[2:1]};
            if (idx == 5'd6) ins = mk(OP_MULST, S_STEP, S_GROW, T_G);
            else if (!idx[0]) ins = mk(OP_MUL, T_H6, T_S0 + n, T_D0 + n);
            else ins = mk(OP_ADDS, S_CUR + n, T_D0 + n, T_N0 + n);
         end
      endcase
      return ins;
   endfunction

endpackage

### hdl/crk_unit.sv
// ----------------------------------------------------------------------------
// crk_unit
// shared arithmetic unit: one multiplier plus add, saturate and shift paths
// ----------------------------------------------------------------------------
module crk_unit (
   input  logic [3:0]                    op,
   input  logic signed [crk_pkg::TW-1:0] opa,
   input  logic signed [crk_pkg::TW-1:0] opb,
   output logic signed [crk_pkg::TW-1:0] result
);

   logic signed [crk_pkg::PW-1:0] aw;
   logic signed [crk_pkg::PW-1:0] bw;
   logic signed [crk_pkg::PW-1:0] prod;
   logic signed [crk_pkg::PW-1:0] prod_sh;
   logic signed [crk_pkg::PW-1:0] dif;
   logic signed [crk_pkg::PW-1:0] sum;
   logic signed [crk_pkg::PW-1:0] abs_dif;
   logic signed [crk_pkg::PW-1:0] abs_sum;
   logic signed [crk_pkg::TW-1:0] half;

   always_comb begin
      aw      = crk_pkg::PW'(opa);
      bw      = crk_pkg::PW'(opb);
      prod    = aw * bw;
      prod_sh = prod >>> crk_pkg::FRAC;
      dif     = aw - bw;
      sum     = aw + bw;
      abs_dif = dif[crk_pkg::PW-1] ? -dif : dif;
      abs_sum = sum[crk_pkg::PW-1] ? -sum : sum;
      half    = crk_pkg::crk_sat32(dif);
      case (op)
         crk_pkg::OP_MUL:   result = crk_pkg::crk_sat32(prod_sh);
         crk_pkg::OP_DIV3:  result = prod[crk_pkg::TW+32:33];
         crk_pkg::OP_MULST: begin
            if (prod_sh < 0) result = '0;
            else if (prod_sh > 72'sd2147483647) result = 36'sd2147483647;
            else result = prod_sh[crk_pkg::TW-1:0];
         end
         crk_pkg::OP_ADD:   result = sum[crk_pkg::TW-1:0];
         crk_pkg::OP_ADDS:  result = crk_pkg::crk_sat32(sum);
         crk_pkg::OP_SUBS:  result = crk_pkg::crk_sat32(dif);
         crk_pkg::OP_NSUBS: result = crk_pkg::crk_sat32(-sum);
         crk_pkg::OP_ABSD:  result = crk_pkg::crk_sat32(abs_dif - abs_sum);
         crk_pkg::OP_SUBH:  result = half >>> 1;
         crk_pkg::OP_SHR1:  result = opa >>> 1;
         default:           result = '0;
      endcase
   end

endmodule

### hdl/crk_tmp_ram.sv
// ----------------------------------------------------------------------------
// crk_tmp_ram
// scratch memory: one write port, two registered read ports
// ----------------------------------------------------------------------------
module crk_tmp_ram (
   input  logic                          clock,
   input  crk_pkg::ram_ctl_type          ctl,
   input  logic [crk_pkg::TW-1:0]        wdata,
   output logic [crk_pkg::TW-1:0]        rdata_a,
   output logic [crk_pkg::TW-1:0]        rdata_b
);

   logic [crk_pkg::TW-1:0] mem [crk_pkg::RAMD];

   always_ff @(posedge clock) begin
      if (ctl.we) mem[ctl.waddr] <= wdata;
      rdata_a <= mem[ctl.raddr_a];
      rdata_b <= mem[ctl.raddr_b];
   end

endmodule

### hdl/chua_rk4_adaptive_step.sv
// ----------------------------------------------------------------------------
// chua_rk4_adaptive_step
// one rk4 attempt on chua's circuit per step beat, q8.24, adaptive step size
// ----------------------------------------------------------------------------
// a load beat goes straight to the done state; a step beat runs 123 microinstructions,
//   each a fetch state then an exec state, on the one shared multiplier
// req_tready only while idle: no new beat is taken before the last one is done
// reset: synchronous, clears state, step, time, count, registers and handshakes
// ----------------------------------------------------------------------------
module chua_rk4_adaptive_step (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [95:0]  req_tdata,   // init_current, init_volt_one, init_volt_two
   input  logic         req_tuser,   // opcode
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [183:0] rsp_tdata,   // out_current, out_volt_one, out_volt_two,
                                     // out_time, out_step, halvings, pad
   output logic         rsp_tuser,   // accepted
   input  logic         csr_we,
   input  logic [2:0]   csr_addr,
   input  logic [63:0]  csr_wdata
);

   // sequencer states
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_FETCH  = 3'd1;
   localparam logic [2:0] ST_EXEC   = 3'd2;
   localparam logic [2:0] ST_CHECK  = 3'd3;
   localparam logic [2:0] ST_COMMIT = 3'd4;
   localparam logic [2:0] ST_DONE   = 3'd5;

   logic [2:0]  state_ff;
   logic [1:0]  phase_ff;
   logic [1:0]  stage_ff;
   logic [4:0]  idx_ff;

   logic [63:0] cfg_ff [crk_pkg::NREG];

   // integrator state
   logic signed [31:0]            cur_ff;
   logic signed [31:0]            v1_ff;
   logic signed [31:0]            v2_ff;
   logic [crk_pkg::STEPW-1:0]     step_ff;
   logic [crk_pkg::TIMEW-1:0]     time_ff;
   logic [crk_pkg::CNTW-1:0]      count_ff;
   logic                          ok_ff;

   // results captured off the writeback path
   logic signed [crk_pkg::TW-1:0] d_ff [3];
   logic signed [crk_pkg::TW-1:0] n_ff [3];
   logic [crk_pkg::STEPW-1:0]     grow_ff;
   logic                          reject_ff;

   // operand path
   crk_pkg::instr_type            ins;
   crk_pkg::instr_type            ins_ff;
   crk_pkg::ram_ctl_type          ram_ctl;
   logic signed [crk_pkg::TW-1:0] side_a_ff;
   logic signed [crk_pkg::TW-1:0] side_b_ff;
   logic [crk_pkg::TW-1:0]        ram_a;
   logic [crk_pkg::TW-1:0]        ram_b;
   logic signed [crk_pkg::TW-1:0] opa;
   logic signed [crk_pkg::TW-1:0] opb;
   logic signed [crk_pkg::TW-1:0] result;

   logic                          req_fire;
   logic                          out_free;
   logic [crk_pkg::TIMEW:0]       time_sum;
   logic signed [crk_pkg::TW-1:0] abs_d [3];
   logic signed [crk_pkg::TW-1:0] ilim;
   logic signed [crk_pkg::TW-1:0] ulim;
   logic signed [31:0]            h0;
   logic                          reject_in;

   // register half or state selected by an operand code
   function automatic logic signed [crk_pkg::TW-1:0] side_sel(input logic [5:0] src,
         input logic [63:0] c [crk_pkg::NREG], input logic signed [31:0] cu,
         input logic signed [31:0] u1, input logic signed [31:0] u2,
         input logic [crk_pkg::STEPW-1:0] st);
      logic [5:0]                    k;
      logic [31:0]                   half;
      logic signed [crk_pkg::TW-1:0] r;
      k    = src - crk_pkg::S_INV_RC1;
      half = k[0] ? c[k[3:1]][31:0] : c[k[3:1]][63:32];
      case (src)
         crk_pkg::S_CUR:    r = crk_pkg::TW'(cu);
         crk_pkg::S_V1:     r = crk_pkg::TW'(u1);
         crk_pkg::S_V2:     r = crk_pkg::TW'(u2);
         crk_pkg::S_STEP:   r = {5'd0, st};
         crk_pkg::S_RECIP3: r = crk_pkg::RECIP3;
         crk_pkg::S_ZERO:   r = '0;
         default:           r = crk_pkg::TW'($signed(half));
      endcase
      return r;
   endfunction

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid || rsp_tready;

   assign ins = crk_pkg::crk_instr(phase_ff, stage_ff, idx_ff);

   always_comb begin
      ram_ctl.we      = (state_ff == ST_EXEC);
      ram_ctl.waddr   = ins_ff.dst;
      ram_ctl.raddr_a = ins.src_a[4:0];
      ram_ctl.raddr_b = ins.src_b[4:0];
   end

   crk_tmp_ram u_ram (
      .clock   (clock),
      .ctl     (ram_ctl),
      .wdata   (result),
      .rdata_a (ram_a),
      .rdata_b (ram_b)
   );

   assign opa = ins_ff.src_a[5] ? side_a_ff : $signed(ram_a);
   assign opb = ins_ff.src_b[5] ? side_b_ff : $signed(ram_b);

   crk_unit u_unit (
      .op     (ins_ff.op),
      .opa    (opa),
      .opb    (opb),
      .result (result)
   );

   // operand fetch beside the ram read
   always_ff @(posedge clock) begin
      if (state_ff == ST_FETCH) begin
         ins_ff    <= ins;
         side_a_ff <= side_sel(ins.src_a, cfg_ff, cur_ff, v1_ff, v2_ff, step_ff);
         side_b_ff <= side_sel(ins.src_b, cfg_ff, cur_ff, v1_ff, v2_ff, step_ff);
      end
   end

   // increments, new state and grown step caught as they are written back
   always_ff @(posedge clock) begin
      if (state_ff == ST_EXEC) begin
         for (int n = 0; n < 3; n++) begin
            if (ins_ff.dst == 5'(crk_pkg::T_D0 + 6'(n))) d_ff[n] <= result;
            if (ins_ff.dst == 5'(crk_pkg::T_N0 + 6'(n))) n_ff[n] <= result;
         end
         if (ins_ff.dst == crk_pkg::T_G[4:0]) grow_ff <= result[crk_pkg::STEPW-1:0];
      end
   end

   // limit check on the three increments
   always_comb begin
      ilim = crk_pkg::TW'($signed(cfg_ff[7][63:32]));
      ulim = crk_pkg::TW'($signed(cfg_ff[7][31:0]));
      for (int n = 0; n < 3; n++) abs_d[n] = d_ff[n][crk_pkg::TW-1] ? -d_ff[n] : d_ff[n];
      reject_in = (abs_d[0] > ilim) || (abs_d[1] > ulim) || (abs_d[2] > ulim);
      time_sum  = {1'b0, time_ff} + {10'd0, step_ff};
      h0        = $signed(cfg_ff[6][63:32]);
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_CHECK) reject_ff <= reject_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < crk_pkg::NREG; r++) cfg_ff[r] <= '0;
      end else if (csr_we) begin
         cfg_ff[csr_addr] <= csr_wdata;
      end
   end

   // sequencer and state update
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= crk_pkg::PH_PRE;
         stage_ff <= '0;
         idx_ff   <= '0;
         cur_ff   <= '0;
         v1_ff    <= '0;
         v2_ff    <= '0;
         step_ff  <= '0;
         time_ff  <= '0;
         count_ff <= '0;
         ok_ff    <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  if (!req_tuser) begin
                     // load beat
                     cur_ff   <= $signed(req_tdata[31:0]);
                     v1_ff    <= $signed(req_tdata[63:32]);
                     v2_ff    <= $signed(req_tdata[95:64]);
                     step_ff  <= h0[31] ? '0 : h0[crk_pkg::STEPW-1:0];
                     time_ff  <= '0;
                     count_ff <= '0;
                     ok_ff    <= 1'b1;
                     state_ff <= ST_DONE;
                  end else begin
                     phase_ff <= crk_pkg::PH_PRE;
                     stage_ff <= '0;
                     idx_ff   <= '0;
                     state_ff <= ST_FETCH;
                  end
               end
            end
            ST_FETCH: state_ff <= ST_EXEC;
            ST_EXEC: begin
               state_ff <= ST_FETCH;
               if (idx_ff != crk_pkg::crk_last(phase_ff, stage_ff)) begin
                  idx_ff <= idx_ff + 5'd1;
               end else begin
                  idx_ff <= '0;
                  case (phase_ff)
                     crk_pkg::PH_PRE:   phase_ff <= crk_pkg::PH_SLOPE;
                     crk_pkg::PH_SLOPE: phase_ff <= crk_pkg::PH_POST;
                     crk_pkg::PH_POST: begin
                        if (stage_ff == 2'd3) begin
                           phase_ff <= crk_pkg::PH_FINAL;
                        end else begin
                           phase_ff <= crk_pkg::PH_SLOPE;
                           stage_ff <= stage_ff + 2'd1;
                        end
                     end
                     default: state_ff <= ST_CHECK;
                  endcase
               end
            end
            ST_CHECK: state_ff <= ST_COMMIT;
            ST_COMMIT: begin
               ok_ff <= !reject_ff;
               if (reject_ff) begin
                  // halve and count
                  step_ff <= step_ff >> 1;
                  if (count_ff != crk_pkg::COUNT_MAX) count_ff <= count_ff + 1'b1;
               end else begin
                  cur_ff  <= n_ff[0][31:0];
                  v1_ff   <= n_ff[1][31:0];
                  v2_ff   <= n_ff[2][31:0];
                  step_ff <= grow_ff;
                  time_ff <= time_sum[crk_pkg::TIMEW] ? crk_pkg::TIME_MAX
                                                       : time_sum[crk_pkg::TIMEW-1:0];
               end
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (out_free) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid <= 1'b0;
      end else if (state_ff == ST_DONE && out_free) begin
         rsp_tvalid <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE && out_free) begin
         rsp_tdata <= {1'b0, count_ff, step_ff, time_ff, v2_ff, v1_ff, cur_ff};
         rsp_tuser <= ok_ff;
      end
   end

   // a step beat always starts the microprogram at its first instruction
   a_step_starts: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tuser) |=> (state_ff == ST_FETCH && idx_ff == 5'd0
                                   && phase_ff == crk_pkg::PH_PRE))
      else $error("step beat did not start the sequencer");

   // time only moves back on a load
   a_time_monotonic: assert property (@(posedge clock) disable iff (reset)
      !(req_fire && !req_tuser) |=> (time_ff >= $past(time_ff)))
      else $error("simulated time went backwards");

   // a halving bumps the count unless it is saturated
   a_count_bump: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMMIT && reject_ff && count_ff != crk_pkg::COUNT_MAX)
      |=> (count_ff == $past(count_ff) + 1'b1) && !ok_ff)
      else $error("rejected step did not bump the count");

   // the operand side only changes while fetching
   a_fetch_only: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC) |=> $stable(ins_ff))
      else $error("instruction changed outside fetch");

endmodule
